[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the priority thread scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned MaxThreads = 8;
  localparam int unsigned NumSems    = 8;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_KILL    = 3'd1,
    CMD_SLEEP   = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_SCHED   = 3'd4,
    CMD_WAIT    = 3'd5,
    CMD_SIGNAL  = 3'd6,
    CMD_SEMSET  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_LAST      = 3'd2,
    ST_NO_THREAD = 3'd3,
    ST_NO_WAITER = 3'd4
  } status_e;

  // one slot presented to the compare unit on a ring walk step
  typedef struct packed {
    logic        active;
    logic        ready;
    logic [7:0]  prio;
    logic        blocked;
    logic [2:0]  block_sem;
    logic [2:0]  next;
  } slot_view_t;

  // compare unit result for one step
  typedef struct packed {
    logic better;
    logic waiter;
    logic pred;
  } step_res_t;

endpackage

[rtl/pts_step_unit.sv]
// ----------------------------------------------------------------------------
// pts_step_unit
// shared compare unit used once per ring walk step
// ----------------------------------------------------------------------------
module pts_step_unit (
  input  pts_pkg::slot_view_t view_i,
  input  logic [8:0]          best_prio_i,
  input  logic [2:0]          sem_id_i,
  input  logic [2:0]          target_i,
  output pts_pkg::step_res_t  res_o
);
  always_comb begin
    res_o.better = view_i.ready && ({1'b0, view_i.prio} < best_prio_i);
    res_o.waiter = view_i.active && view_i.blocked && (view_i.block_sem == sem_id_i);
    res_o.pred   = (view_i.next == target_i);
  end
endmodule

[rtl/priority_thread_scheduler.sv]
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// command driven thread slot scheduler with semaphores
// ----------------------------------------------------------------------------
// One command is taken at a time. Simple commands pass through the execute
// state and then present their result in the output register. Create scans
// the slots for a free one, kill finds the predecessor of the running slot,
// schedule and signal walk the ring: each of these visits up to 8 slots, and
// kill, schedule and signal test each visited slot through one shared compare
// unit. tready is low while a command is in work or its result waits in the
// output register, and comes back in the cycle after the output transfer, so a
// new command is taken only once the last result has been transferred.
module priority_thread_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0], priority_req[10:3], sleep_ms[42:11], sem_id[45:43],
  // sem_value[61:46], zero[63:62]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], running_thread[5:3], new_slot[8:6], reschedule[9],
  // sem_count[25:10], active_count[29:26], zero[31:30]
  output logic [31:0] m_axis_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_WALK, S_OUT} state_e;

  state_e      state_q;
  logic [2:0]  cmd_q;
  logic [7:0]  prio_q;
  logic [31:0] ms_q;
  logic [2:0]  sid_q;
  logic [15:0] sval_q;

  logic [7:0]  act_q, blk_q;
  logic [7:0]  pri_q  [8];
  logic [31:0] slp_q  [8];
  logic [2:0]  nxt_q  [8];
  logic [2:0]  bsem_q [8];
  logic [15:0] sem_q  [8];
  logic [2:0]  run_q;
  logic [3:0]  tot_q;

  logic [2:0]  cur_q, best_q;
  logic [8:0]  bestp_q;
  logic [3:0]  cnt_q;
  logic [2:0]  st_q, new_q;
  logic        rs_q;

  pts_pkg::slot_view_t view;
  pts_pkg::step_res_t  res;

  always_comb begin
    view.active    = act_q[cur_q];
    view.ready     = (slp_q[cur_q] == 32'd0) && !blk_q[cur_q];
    view.prio      = pri_q[cur_q];
    view.blocked   = blk_q[cur_q];
    view.block_sem = bsem_q[cur_q];
    view.next      = nxt_q[cur_q];
  end

  pts_step_unit u_step (
    .view_i(view), .best_prio_i(bestp_q), .sem_id_i(sid_q),
    .target_i(run_q), .res_o(res)
  );

  logic run_live;
  assign run_live = (tot_q != 4'd0) && act_q[run_q];
  logic [15:0] semc;
  assign semc = sem_q[sid_q];

  // commands that go on to a slot scan or ring walk after the execute cycle
  logic exec_walk;
  always_comb begin
    unique case (pts_pkg::cmd_e'(cmd_q))
      pts_pkg::CMD_CREATE: exec_walk = (tot_q != 4'd0) && (tot_q < 4'd8) && run_live;
      pts_pkg::CMD_KILL:   exec_walk = run_live && (tot_q > 4'd1);
      pts_pkg::CMD_SCHED:  exec_walk = (tot_q != 4'd0);
      pts_pkg::CMD_SIGNAL: exec_walk = ($signed(semc) < 16'sd0) && (tot_q != 4'd0);
      default:             exec_walk = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {2'b00, tot_q, semc, rs_q, new_q, run_q, st_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= '0;
      blk_q   <= '0;
      run_q   <= '0;
      tot_q   <= '0;
      for (int k = 0; k < 8; k++) begin
        slp_q[k] <= '0;
        sem_q[k] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q  <= s_axis_tdata[2:0];
            prio_q <= s_axis_tdata[10:3];
            ms_q   <= s_axis_tdata[42:11];
            sid_q  <= s_axis_tdata[45:43];
            sval_q <= s_axis_tdata[61:46];
            st_q   <= pts_pkg::ST_OK;
            new_q  <= '0;
            rs_q   <= 1'b0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= exec_walk ? S_WALK : S_OUT;
          unique case (pts_pkg::cmd_e'(cmd_q))
            pts_pkg::CMD_CREATE: begin
              if (tot_q == 4'd0) begin
                act_q[0] <= 1'b1; pri_q[0] <= prio_q; slp_q[0] <= '0;
                blk_q[0] <= 1'b0; bsem_q[0] <= '0; nxt_q[0] <= '0;
                run_q <= '0; tot_q <= 4'd1;
              end else if (tot_q >= 4'd8) st_q <= pts_pkg::ST_FULL;
              else if (!run_live) st_q <= pts_pkg::ST_NO_THREAD;
              else cur_q <= '0;
            end
            pts_pkg::CMD_KILL: begin
              if (!run_live) st_q <= pts_pkg::ST_NO_THREAD;
              else if (tot_q <= 4'd1) st_q <= pts_pkg::ST_LAST;
              else begin
                cur_q <= nxt_q[run_q]; cnt_q <= '0;
              end
            end
            pts_pkg::CMD_SLEEP: begin
              if (!run_live) st_q <= pts_pkg::ST_NO_THREAD;
              else begin slp_q[run_q] <= ms_q; rs_q <= 1'b1; end
            end
            pts_pkg::CMD_TICK: begin
              for (int k = 0; k < 8; k++)
                if (slp_q[k] != 32'd0) slp_q[k] <= slp_q[k] - 32'd1;
            end
            pts_pkg::CMD_SCHED: begin
              if (tot_q == 4'd0) st_q <= pts_pkg::ST_NO_THREAD;
              else begin
                cur_q <= nxt_q[run_q]; best_q <= nxt_q[run_q];
                bestp_q <= 9'd256; cnt_q <= '0;
              end
            end
            pts_pkg::CMD_WAIT: begin
              if (!run_live) st_q <= pts_pkg::ST_NO_THREAD;
              else begin
                if (semc != 16'h8000) sem_q[sid_q] <= semc - 16'd1;
                if ($signed(semc) <= 16'sd0) begin
                  blk_q[run_q] <= 1'b1; bsem_q[run_q] <= sid_q; rs_q <= 1'b1;
                end
              end
            end
            pts_pkg::CMD_SIGNAL: begin
              if (semc != 16'h7FFF) sem_q[sid_q] <= semc + 16'd1;
              // raised count still <= 0 means someone waits
              if ($signed(semc) < 16'sd0) begin
                if (tot_q == 4'd0) st_q <= pts_pkg::ST_NO_WAITER;
                else begin
                  cur_q <= nxt_q[run_q]; cnt_q <= '0;
                end
              end
            end
            default: sem_q[sid_q] <= sval_q;
          endcase
        end
        S_WALK: begin
          unique case (pts_pkg::cmd_e'(cmd_q))
            pts_pkg::CMD_CREATE: begin
              if (!act_q[cur_q]) begin
                act_q[cur_q] <= 1'b1; pri_q[cur_q] <= prio_q; slp_q[cur_q] <= '0;
                blk_q[cur_q] <= 1'b0; bsem_q[cur_q] <= '0;
                nxt_q[cur_q] <= nxt_q[run_q]; nxt_q[run_q] <= cur_q;
                tot_q <= tot_q + 4'd1; new_q <= cur_q; state_q <= S_OUT;
              end else if (cur_q == 3'd7) begin
                st_q <= pts_pkg::ST_FULL; state_q <= S_OUT;
              end else cur_q <= cur_q + 3'd1;
            end
            pts_pkg::CMD_KILL: begin
              if (res.pred || cnt_q == 4'd7) begin
                nxt_q[cur_q] <= nxt_q[run_q]; act_q[run_q] <= 1'b0;
                tot_q <= tot_q - 4'd1; rs_q <= 1'b1; state_q <= S_OUT;
              end else begin
                cur_q <= nxt_q[cur_q]; cnt_q <= cnt_q + 4'd1;
              end
            end
            pts_pkg::CMD_SCHED: begin
              logic [2:0] b;
              b = res.better ? cur_q : best_q;
              if (res.better) begin best_q <= cur_q; bestp_q <= {1'b0, view.prio}; end
              if (cnt_q + 4'd1 >= tot_q) begin run_q <= b; state_q <= S_OUT; end
              else begin cur_q <= nxt_q[cur_q]; cnt_q <= cnt_q + 4'd1; end
            end
            default: begin
              if (res.waiter) begin
                blk_q[cur_q] <= 1'b0; state_q <= S_OUT;
              end else if (cnt_q + 4'd1 >= tot_q) begin
                st_q <= pts_pkg::ST_NO_WAITER; state_q <= S_OUT;
              end else begin
                cur_q <= nxt_q[cur_q]; cnt_q <= cnt_q + 4'd1;
              end
            end
          endcase
        end
        default: if (m_axis_tready) state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) tot_q <= 4'd8)
    else $error("thread count above table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == S_EXEC)
    else $error("accepted command not executed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");
endmodule
